>>> rtl/dsa_pkg.sv
// ----------------------------------------------------------------------------
// dsa_pkg
// Shared constants, payload types and controller/datapath links for the
// dedispersion subband averager.
// ----------------------------------------------------------------------------
package dsa_pkg;

	// sizing of the stores
	localparam int LANES       = 2048;
	localparam int MAX_DELAY   = 255;
	localparam int SLOTS       = MAX_DELAY + 1;
	localparam int LANE_W      = $clog2(LANES);
	localparam int SLOT_W      = $clog2(SLOTS);
	localparam int STORE_DEPTH = LANES * SLOTS;
	localparam int STORE_AW    = $clog2(STORE_DEPTH);

	// field widths
	localparam int SAMPLE_W = 8;
	localparam int SEL_W    = 11;
	localparam int DELAY_W  = 8;
	localparam int GRP_W    = 11;
	localparam int TBL_W    = DELAY_W + 1;

	// good-lane count, accumulator holds lanes * 128 plus the rounding half
	localparam int CNT_W = $clog2(LANES + 1);
	localparam int SUM_W = $clog2(LANES * 129) + 1;
	localparam int DS_W  = (DELAY_W > SLOT_W) ? DELAY_W : SLOT_W;

	// configuration registers
	localparam int CFG_W     = 12;
	localparam int CFG_IDX_W = 1;
	localparam int EXT_W     = (CFG_W > CNT_W) ? CFG_W : CNT_W;
	localparam logic [CFG_IDX_W-1:0] REG_LANES_IN_USE    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_LANES_PER_GROUP = 1'b1;
	localparam logic [CFG_W-1:0]     LANES_RESET         = 12'd2048;
	localparam logic [CFG_W-1:0]     GROUP_RESET         = 12'd16;

	// item opcodes
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_TABLE  = 1'b1;

	typedef struct packed {
		logic                       opcode;
		logic signed [SAMPLE_W-1:0] sample;
		logic [SEL_W-1:0]           lane_select;
		logic [DELAY_W-1:0]         lane_delay;
		logic                       lane_weight;
	} item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] subband_value;
		logic [GRP_W-1:0]           group_index;
		logic                       frame_last;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic table_wr;
		logic sample_wr;
		logic eval;
		logic sync_start;
		logic sync_load;
		logic walk_step;
		logic avg_start;
		logic out_load;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clearing;
		logic resync;
		logic group_end;
		logic walk_last;
		logic pipe_empty;
		logic div_done;
		logic out_free;
	} dp_status_t;

endpackage

>>> rtl/dsa_ram.sv
// ----------------------------------------------------------------------------
// dsa_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module dsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/dsa_div.sv
// ----------------------------------------------------------------------------
// dsa_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dsa_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [dsa_pkg::SUM_W-1:0] dividend,
	input  logic [dsa_pkg::CNT_W-1:0] divisor,
	output logic                      done,
	output logic [dsa_pkg::SUM_W-1:0] quotient,
	output logic [dsa_pkg::CNT_W-1:0] remainder
);

	localparam int CYC_W = $clog2(dsa_pkg::SUM_W);

	logic                      busy_q;
	logic                      done_q;
	logic [CYC_W-1:0]          cnt_q;
	logic [dsa_pkg::SUM_W-1:0] quo_q;
	logic [dsa_pkg::CNT_W-1:0] rem_q;
	logic [dsa_pkg::CNT_W-1:0] dvs_q;
	logic [dsa_pkg::CNT_W:0]   trial;
	logic [dsa_pkg::CNT_W:0]   dvs_x;
	logic                      fits;

	// trial subtract of the shifted partial remainder
	assign trial = {rem_q, quo_q[dsa_pkg::SUM_W-1]};
	assign dvs_x = {1'b0, dvs_q};
	assign fits  = trial >= dvs_x;

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CYC_W'(dsa_pkg::SUM_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CYC_W'(1);
				end
			end
		end
	end

	// quotient and remainder shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[dsa_pkg::SUM_W-2:0], fits};
			rem_q <= fits ? dsa_pkg::CNT_W'(trial - dvs_x) : trial[dsa_pkg::CNT_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

>>> rtl/dsa_datapath.sv
// ----------------------------------------------------------------------------
// dsa_datapath
// Configuration, lane/frame counters, sample store and lane table, group
// walk pipeline, accumulator, shared divider and result register.
// ----------------------------------------------------------------------------
module dsa_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dsa_pkg::ctrl_cmd_t            cmd,
	output dsa_pkg::dp_status_t           status,
	input  dsa_pkg::item_t                item,
	input  logic                          cfg_we,
	input  logic [dsa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dsa_pkg::CFG_W-1:0]     cfg_data,
	output logic                          result_valid,
	input  logic                          result_stall,
	output dsa_pkg::result_t              result
);

	localparam int LW = dsa_pkg::LANE_W;
	localparam int SW = dsa_pkg::SLOT_W;
	localparam int AW = dsa_pkg::STORE_AW;
	localparam int CW = dsa_pkg::CNT_W;
	localparam int XW = dsa_pkg::EXT_W;
	localparam int MW = dsa_pkg::SUM_W;
	localparam int DW = dsa_pkg::DS_W;

	// configuration and position state
	logic [dsa_pkg::CFG_W-1:0] lanes_cfg_q;
	logic [dsa_pkg::CFG_W-1:0] group_cfg_q;
	logic                      resync_q;
	logic [LW-1:0]             pos_q;
	logic [LW-1:0]             grp_idx_q;
	logic [LW-1:0]             off_q;
	logic [SW-1:0]             slot_q;

	// clearing pass
	logic          clearing_q;
	logic [AW-1:0] clr_addr_q;

	// walk state
	logic [LW-1:0] walk_l_q;
	logic [LW-1:0] walk_end_q;
	logic [SW-1:0] walk_slot_q;
	logic [LW-1:0] res_group_q;
	logic          res_last_q;
	logic          v_s1;
	logic          v_s2;
	logic [LW-1:0] lane_s1;
	logic          w_s2;

	// accumulation and result
	logic signed [MW-1:0] sum_acc_q;
	logic [CW-1:0]        cnt_acc_q;
	logic                 neg_q;
	logic                 zero_q;
	logic                 result_valid_q;
	dsa_pkg::result_t     result_q;

	// combinational
	logic [XW-1:0]                      lanes_x;
	logic [XW-1:0]                      group_x;
	logic [CW-1:0]                      lanes_eff;
	logic [CW-1:0]                      grp_eff;
	logic [LW-1:0]                      lanes_m1;
	logic                               last_frame;
	logic [LW-1:0]                      pos_clip;
	logic [CW-1:0]                      off_inc;
	logic                               group_full;
	logic [dsa_pkg::TBL_W-1:0]          tbl_rdata;
	logic [dsa_pkg::SAMPLE_W-1:0]       store_rdata;
	logic                               tbl_we;
	logic [LW-1:0]                      tbl_waddr;
	logic [dsa_pkg::TBL_W-1:0]          tbl_wdata;
	logic                               store_we;
	logic [AW-1:0]                      store_waddr;
	logic [dsa_pkg::SAMPLE_W-1:0]       store_wdata;
	logic [AW-1:0]                      store_raddr;
	logic [DW-1:0]                      d_sat;
	logic [DW:0]                        slot_x;
	logic [DW:0]                        d_x;
	logic [DW:0]                        rd_slot_x;
	logic [SW-1:0]                      rd_slot;
	logic signed [MW-1:0]               sum_fin;
	logic [MW-1:0]                      sum_mag;
	logic                               div_start;
	logic [MW-1:0]                      div_dividend;
	logic [CW-1:0]                      div_divisor;
	logic                               div_done;
	logic [MW-1:0]                      div_quo;
	logic [CW-1:0]                      div_rem;
	logic [dsa_pkg::SAMPLE_W-1:0]       q8;
	logic [dsa_pkg::SAMPLE_W-1:0]       avg_val;

	// effective lane count and group size
	always_comb begin
		lanes_x = XW'(lanes_cfg_q);
		if (lanes_x == '0) begin
			lanes_x = XW'(1);
		end
		if (lanes_x > XW'(dsa_pkg::LANES)) begin
			lanes_x = XW'(dsa_pkg::LANES);
		end
		group_x = XW'(group_cfg_q);
		if (group_x == '0) begin
			group_x = XW'(1);
		end
		if (group_x > lanes_x) begin
			group_x = lanes_x;
		end
	end

	assign lanes_eff = CW'(lanes_x);
	assign grp_eff   = CW'(group_x);

	// current lane, clipped to the last lane of the frame
	assign lanes_m1   = LW'(lanes_eff - CW'(1));
	assign last_frame = pos_q >= lanes_m1;
	assign pos_clip   = last_frame ? lanes_m1 : pos_q;
	assign off_inc    = CW'(off_q) + CW'(1);
	assign group_full = off_inc == grp_eff;

	// configuration registers, any write forces a group resync
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lanes_cfg_q <= dsa_pkg::LANES_RESET;
			group_cfg_q <= dsa_pkg::GROUP_RESET;
			resync_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					dsa_pkg::REG_LANES_IN_USE:    lanes_cfg_q <= cfg_data;
					dsa_pkg::REG_LANES_PER_GROUP: group_cfg_q <= cfg_data;
				endcase
				resync_q <= 1'b1;
			end else if (cmd.sync_load) begin
				resync_q <= 1'b0;
			end
		end
	end

	// lane, group and frame slot counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			grp_idx_q <= '0;
			off_q     <= '0;
			slot_q    <= '0;
		end else if (cmd.sync_load) begin
			pos_q     <= pos_clip;
			grp_idx_q <= LW'(div_quo);
			off_q     <= LW'(div_rem);
		end else if (cmd.eval) begin
			if (last_frame) begin
				pos_q     <= '0;
				grp_idx_q <= '0;
				off_q     <= '0;
				slot_q    <= (32'(slot_q) == dsa_pkg::MAX_DELAY) ? '0 : slot_q + SW'(1);
			end else begin
				pos_q <= pos_clip + LW'(1);
				if (group_full) begin
					grp_idx_q <= grp_idx_q + LW'(1);
					off_q     <= '0;
				end else begin
					off_q <= off_q + LW'(1);
				end
			end
		end
	end

	// clearing pass over both stores after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(dsa_pkg::STORE_DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// walk bounds and lane read pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.walk_step;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			walk_l_q    <= pos_clip - off_q;
			walk_end_q  <= pos_clip;
			walk_slot_q <= slot_q;
			res_group_q <= grp_idx_q;
			res_last_q  <= last_frame;
		end else if (cmd.walk_step) begin
			walk_l_q <= walk_l_q + LW'(1);
		end
		lane_s1 <= walk_l_q;
		w_s2    <= tbl_rdata[dsa_pkg::DELAY_W];
	end

	// lane table: clear pass or table-write transaction
	assign tbl_we    = (clearing_q && (clr_addr_q < AW'(dsa_pkg::LANES))) ||
	                   (cmd.table_wr && (32'(item.lane_select) < dsa_pkg::LANES));
	assign tbl_waddr = clearing_q ? LW'(clr_addr_q) : LW'(item.lane_select);
	assign tbl_wdata = clearing_q ? '0 : {item.lane_weight, item.lane_delay};

	dsa_ram #(
		.WIDTH(dsa_pkg::TBL_W),
		.DEPTH(dsa_pkg::LANES)
	) u_table (
		.clk  (clk),
		.we   (tbl_we),
		.waddr(tbl_waddr),
		.wdata(tbl_wdata),
		.raddr(walk_l_q),
		.rdata(tbl_rdata)
	);

	// delayed slot of the lane read in stage one
	always_comb begin
		d_sat = (32'(tbl_rdata[dsa_pkg::DELAY_W-1:0]) > dsa_pkg::MAX_DELAY) ?
		        DW'(dsa_pkg::MAX_DELAY) : DW'(tbl_rdata[dsa_pkg::DELAY_W-1:0]);
		slot_x = (DW+1)'(walk_slot_q);
		d_x    = (DW+1)'(d_sat);
		if (slot_x >= d_x) begin
			rd_slot_x = slot_x - d_x;
		end else begin
			rd_slot_x = slot_x + (DW+1)'(dsa_pkg::SLOTS) - d_x;
		end
		rd_slot = SW'(rd_slot_x);
	end

	// sample store: clear pass or current sample
	assign store_we    = clearing_q || cmd.sample_wr;
	assign store_waddr = clearing_q ? clr_addr_q :
	                     AW'(slot_q) * AW'(dsa_pkg::LANES) + AW'(pos_clip);
	assign store_wdata = clearing_q ? '0 : item.sample;
	assign store_raddr = AW'(rd_slot) * AW'(dsa_pkg::LANES) + AW'(lane_s1);

	dsa_ram #(
		.WIDTH(dsa_pkg::SAMPLE_W),
		.DEPTH(dsa_pkg::STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (store_we),
		.waddr(store_waddr),
		.wdata(store_wdata),
		.raddr(store_raddr),
		.rdata(store_rdata)
	);

	// accumulate good lanes in stage two
	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			sum_acc_q <= '0;
			cnt_acc_q <= '0;
		end else if (v_s2 && w_s2) begin
			sum_acc_q <= sum_acc_q + MW'(signed'(store_rdata));
			cnt_acc_q <= cnt_acc_q + CW'(1);
		end
	end

	// rounding half and sign split ahead of the divider
	assign sum_fin = sum_acc_q + $signed(MW'(cnt_acc_q >> 1));
	assign sum_mag = sum_fin[MW-1] ? MW'(-sum_fin) : MW'(sum_fin);

	always_ff @(posedge clk) begin
		if (cmd.avg_start) begin
			neg_q  <= sum_fin[MW-1];
			zero_q <= cnt_acc_q == '0;
		end
	end

	// shared divider: group resync or group average
	assign div_start    = cmd.sync_start || cmd.avg_start;
	assign div_dividend = cmd.avg_start ? sum_mag : MW'(pos_clip);
	assign div_divisor  = cmd.avg_start ? cnt_acc_q : grp_eff;

	dsa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	// truncate toward zero, empty group gives zero
	assign q8      = div_quo[dsa_pkg::SAMPLE_W-1:0];
	assign avg_val = zero_q ? '0 : (neg_q ? (~q8 + dsa_pkg::SAMPLE_W'(1)) : q8);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			result_q.subband_value <= avg_val;
			result_q.group_index   <= dsa_pkg::GRP_W'(res_group_q);
			result_q.frame_last    <= res_last_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign status.clearing   = clearing_q;
	assign status.resync     = resync_q;
	assign status.group_end  = last_frame || group_full;
	assign status.walk_last  = walk_l_q == walk_end_q;
	assign status.pipe_empty = !v_s1 && !v_s2;
	assign status.div_done   = div_done;
	assign status.out_free   = !result_valid_q || !result_stall;

endmodule

>>> rtl/dsa_ctrl.sv
// ----------------------------------------------------------------------------
// dsa_ctrl
// Sequencer: takes items, runs the group walk, the divide and the result
// hand-off through the datapath.
// ----------------------------------------------------------------------------
module dsa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  logic                opcode,
	input  dsa_pkg::dp_status_t status,
	output dsa_pkg::ctrl_cmd_t  cmd,
	output logic                item_stall
);

	typedef enum logic [7:0] {
		ST_CLEAR = 8'b0000_0001,
		ST_IDLE  = 8'b0000_0010,
		ST_SYNC  = 8'b0000_0100,
		ST_EVAL  = 8'b0000_1000,
		ST_WALK  = 8'b0001_0000,
		ST_DRAIN = 8'b0010_0000,
		ST_DIV   = 8'b0100_0000,
		ST_OUT   = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	// next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				if (!status.clearing) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (item_valid) begin
					if (opcode == dsa_pkg::OP_TABLE) begin
						cmd.table_wr = 1'b1;
					end else begin
						cmd.sample_wr = 1'b1;
						if (status.resync) begin
							cmd.sync_start = 1'b1;
							state_d        = ST_SYNC;
						end else begin
							cmd.eval = 1'b1;
							if (status.group_end) begin
								state_d = ST_WALK;
							end
						end
					end
				end
			end
			ST_SYNC: begin
				if (status.div_done) begin
					cmd.sync_load = 1'b1;
					state_d       = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = status.group_end ? ST_WALK : ST_IDLE;
			end
			ST_WALK: begin
				cmd.walk_step = 1'b1;
				if (status.walk_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (status.pipe_empty) begin
					cmd.avg_start = 1'b1;
					state_d       = ST_DIV;
				end
			end
			ST_DIV: begin
				if (status.div_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign item_stall = state_q != ST_IDLE;

endmodule

>>> rtl/dedispersion_subband_averager.sv
// ----------------------------------------------------------------------------
// dedispersion_subband_averager
// Incoherent dedispersion subbanding: delayed lanes of each group are summed
// and averaged over the good lanes into one subband value.
// ----------------------------------------------------------------------------
// After reset the block zeroes its sample store and lane table in a clearing
// pass over all LANES*(MAX_DELAY+1) entries (524288 at the default sizes) and
// holds item_stall high until it ends. A table-write transaction and a sample
// that does not close a group are taken without holding off the next item. A
// sample that closes a group of n lanes holds off items while the walk reads
// one lane per cycle through the single read port of the sample store, the
// read pipeline drains and a bit-serial divider forms the average. The first
// sample after a register write also holds off items for a divide that
// realigns the group counters. The result sits in an output register, so items
// flow while a result waits, until a later group's result needs the register.
module dedispersion_subband_averager (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  dsa_pkg::item_t                item,
	output logic                          result_valid,
	input  logic                          result_stall,
	output dsa_pkg::result_t              result,
	input  logic                          cfg_we,
	input  logic [dsa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dsa_pkg::CFG_W-1:0]     cfg_data
);

	dsa_pkg::ctrl_cmd_t  cmd;
	dsa_pkg::dp_status_t status;

	// sequencer
	dsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.opcode    (item.opcode),
		.status    (status),
		.cmd       (cmd),
		.item_stall(item_stall)
	);

	// stores, counters, divider and result register
	dsa_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.item        (item),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

endmodule

>>> rtl/dsa_checker.sv
// ----------------------------------------------------------------------------
// dsa_checker
// Port-level assertions for the dedispersion subband averager.
// ----------------------------------------------------------------------------
module dsa_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_stall,
	input dsa_pkg::item_t   item,
	input logic             result_valid,
	input logic             result_stall,
	input dsa_pkg::result_t result
);

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// input is held off as reset is released and the clearing pass begins
	a_clear_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> item_stall)
		else $error("input taken during clearing pass");

	// a table-write transaction does not hold off the next transaction
	a_table_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && (item.opcode == dsa_pkg::OP_TABLE) |=> !item_stall)
		else $error("table write held off the next transaction");

	// a new result only comes out of a busy group computation
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_stall))
		else $error("result appeared without group computation");

endmodule

bind dedispersion_subband_averager dsa_checker u_dsa_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item_valid),
	.item_stall  (item_stall),
	.item        (item),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.result      (result)
);
